### hdl/evpn_rsd_pkg.sv
// ----------------------------------------------------------------------------
// evpn_rsd_pkg
// Types and constants shared by the EVPN route stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package evpn_rsd_pkg;

    localparam logic [7:0] RT_ETH_AD     = 8'd1;
    localparam logic [7:0] RT_MAC_IP     = 8'd2;
    localparam logic [7:0] RT_INC_MCAST  = 8'd3;
    localparam logic [7:0] RT_IP_PREFIX  = 8'd5;

    localparam logic [7:0] MIN_LEN_ETH_AD = 8'd25;
    localparam logic [7:0] MIN_LEN_MAC_IP = 8'd29;
    localparam logic [7:0] MIN_LEN_OTHER  = 8'd23;

    localparam logic [7:0] OFF_ASN_FIRST   = 8'd2;
    localparam logic [7:0] OFF_ASN_LAST    = 8'd3;
    localparam logic [7:0] OFF_RDVAL_FIRST = 8'd4;
    localparam logic [7:0] OFF_RDVAL_LAST  = 8'd7;
    localparam logic [7:0] OFF_TAG_FIRST   = 8'd18;
    localparam logic [7:0] OFF_TAG_LAST    = 8'd21;
    localparam logic [7:0] OFF_PFX_FIRST   = 8'd23;

    localparam logic [7:0] MAC_BITS    = 8'd48;
    localparam logic [7:0] IPV4_BITS   = 8'd32;
    localparam logic [5:0] LABEL_BYTES = 6'd3;
    localparam logic [8:0] HDR_BYTES   = 9'd2;

    typedef enum logic [12:0] {
        PH_TYPE   = 13'b0000000000001,
        PH_LEN    = 13'b0000000000010,
        PH_FIXED  = 13'b0000000000100,
        PH_MACLEN = 13'b0000000001000,
        PH_MACB   = 13'b0000000010000,
        PH_IPLEN  = 13'b0000000100000,
        PH_IPB    = 13'b0000001000000,
        PH_PLEN   = 13'b0000010000000,
        PH_PFX    = 13'b0000100000000,
        PH_GWLEN  = 13'b0001000000000,
        PH_GWB    = 13'b0010000000000,
        PH_LABEL  = 13'b0100000000000,
        PH_TAIL   = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_step;

    typedef struct packed {
        logic        status;
        logic [7:0]  rec_type;
        logic [15:0] rd_asn;
        logic [31:0] rd_value;
        logic [31:0] ethernet_tag;
        logic [19:0] mpls_label;
        logic [7:0]  mac_length;
        logic [47:0] mac_address;
        logic [7:0]  addr_length;
        logic [31:0] addr_value;
        logic [31:0] gateway_addr;
        logic [8:0]  record_length;
    } t_route;

endpackage

`default_nettype wire

### hdl/evpn_rsd_parser.sv
// ----------------------------------------------------------------------------
// evpn_rsd_parser
// Byte-wise parse state and field capture for EVPN route records.
// ----------------------------------------------------------------------------
`default_nettype none

module evpn_rsd_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  evpn_rsd_pkg::t_step  i_step,
    output logic                 o_emit,
    output evpn_rsd_pkg::t_route o_result
);
    import evpn_rsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_draining, n_draining;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_vlen, n_vlen;
    logic [5:0]  r_skip, n_skip;
    logic        r_want, n_want;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_asn, n_asn;
    logic [31:0] r_rdval, n_rdval;
    logic [31:0] r_tag, n_tag;
    logic [23:0] r_label, n_label;
    logic [7:0]  r_maclen, n_maclen;
    logic [47:0] r_mac, n_mac;
    logic [7:0]  r_addrlen, n_addrlen;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_gw, n_gw;

    logic [7:0] b;
    logic       last;
    logic [8:0] b_plus7;
    logic [5:0] nb;
    logic [7:0] min_len;
    logic       known;
    logic [7:0] pidx;
    logic       in_value;
    logic       err;

    assign b       = i_step.data;
    assign last    = i_step.last;
    assign b_plus7 = {1'b0, b} + 9'd7;
    assign nb      = b_plus7[8:3];
    assign pidx    = r_off - OFF_PFX_FIRST;
    assign known   = (b == RT_ETH_AD) || (b == RT_MAC_IP) ||
                     (b == RT_INC_MCAST) || (b == RT_IP_PREFIX);
    assign min_len = (r_type == RT_ETH_AD) ? MIN_LEN_ETH_AD :
                     (r_type == RT_MAC_IP) ? MIN_LEN_MAC_IP : MIN_LEN_OTHER;
    assign in_value = (r_phase != PH_TYPE) && (r_phase != PH_LEN);

    always_comb begin
        n_phase    = r_phase;
        n_draining = r_draining;
        n_off      = r_off;
        n_vlen     = r_vlen;
        n_skip     = r_skip;
        n_want     = r_want;
        n_type     = r_type;
        n_asn      = r_asn;
        n_rdval    = r_rdval;
        n_tag      = r_tag;
        n_label    = r_label;
        n_maclen   = r_maclen;
        n_mac      = r_mac;
        n_addrlen  = r_addrlen;
        n_addr     = r_addr;
        n_gw       = r_gw;
        err        = 1'b0;
        o_emit     = 1'b0;
        o_result   = '0;

        if (i_step.valid && r_draining) begin
            if (last) begin
                n_draining = 1'b0;
                n_phase    = PH_TYPE;
            end
        end else if (i_step.valid) begin
            case (r_phase)
                PH_TYPE: begin
                    n_type    = b;
                    n_asn     = '0;
                    n_rdval   = '0;
                    n_tag     = '0;
                    n_label   = '0;
                    n_maclen  = '0;
                    n_mac     = '0;
                    n_addrlen = '0;
                    n_addr    = '0;
                    n_gw      = '0;
                    n_want    = 1'b0;
                    if (!known || last) begin
                        err = 1'b1;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_vlen = b;
                    if ((b < min_len) || last) begin
                        err = 1'b1;
                    end else begin
                        n_off   = '0;
                        n_phase = PH_FIXED;
                    end
                end
                PH_FIXED: begin
                    if (r_off >= OFF_ASN_FIRST && r_off <= OFF_ASN_LAST) begin
                        n_asn = {r_asn[7:0], b};
                    end else if (r_off >= OFF_RDVAL_FIRST && r_off <= OFF_RDVAL_LAST) begin
                        n_rdval = {r_rdval[23:0], b};
                    end else if (r_off >= OFF_TAG_FIRST && r_off <= OFF_TAG_LAST) begin
                        n_tag = {r_tag[23:0], b};
                    end
                    if (r_off == OFF_TAG_LAST) begin
                        if (r_type == RT_ETH_AD) begin
                            n_phase = PH_LABEL;
                            n_skip  = LABEL_BYTES;
                            n_label = '0;
                        end else if (r_type == RT_MAC_IP) begin
                            n_phase = PH_MACLEN;
                        end else if (r_type == RT_INC_MCAST) begin
                            n_phase = PH_IPLEN;
                        end else begin
                            n_phase = PH_PLEN;
                        end
                    end
                end
                PH_MACLEN: begin
                    n_maclen = b;
                    if (nb == 6'd0) begin
                        n_phase = PH_IPLEN;
                    end else begin
                        n_skip  = nb;
                        n_phase = PH_MACB;
                    end
                end
                PH_MACB: begin
                    if (r_maclen == MAC_BITS) begin
                        n_mac = {r_mac[39:0], b};
                    end
                    n_skip = r_skip - 6'd1;
                    if (n_skip == 6'd0) begin
                        n_phase = PH_IPLEN;
                    end
                end
                PH_IPLEN: begin
                    if (r_type == RT_MAC_IP) begin
                        n_addrlen = b;
                    end
                    n_want = (b == IPV4_BITS);
                    if (nb == 6'd0) begin
                        n_phase = PH_LABEL;
                        n_skip  = LABEL_BYTES;
                        n_label = '0;
                    end else begin
                        n_skip  = nb;
                        n_phase = PH_IPB;
                    end
                end
                PH_IPB: begin
                    if (r_want) begin
                        n_addr = {r_addr[23:0], b};
                    end
                    n_skip = r_skip - 6'd1;
                    if (n_skip == 6'd0) begin
                        n_phase = PH_LABEL;
                        n_skip  = LABEL_BYTES;
                        n_label = '0;
                    end
                end
                PH_PLEN: begin
                    n_addrlen = b;
                    if ({3'b000, nb} + {1'b0, MIN_LEN_OTHER} > {1'b0, r_vlen}) begin
                        err = 1'b1;
                    end else if (nb == 6'd0) begin
                        n_phase = PH_GWLEN;
                    end else begin
                        n_skip  = nb;
                        n_phase = PH_PFX;
                    end
                end
                PH_PFX: begin
                    if (pidx < 8'd4) begin
                        case (pidx[1:0])
                            2'd0:    n_addr[31:24] = r_addr[31:24] | b;
                            2'd1:    n_addr[23:16] = r_addr[23:16] | b;
                            2'd2:    n_addr[15:8]  = r_addr[15:8] | b;
                            default: n_addr[7:0]   = r_addr[7:0] | b;
                        endcase
                    end
                    n_skip = r_skip - 6'd1;
                    if (n_skip == 6'd0) begin
                        n_phase = PH_GWLEN;
                    end
                end
                PH_GWLEN: begin
                    n_want = (b == IPV4_BITS);
                    if (nb == 6'd0) begin
                        n_phase = PH_LABEL;
                        n_skip  = LABEL_BYTES;
                        n_label = '0;
                    end else begin
                        n_skip  = nb;
                        n_phase = PH_GWB;
                    end
                end
                PH_GWB: begin
                    if (r_want) begin
                        n_gw = {r_gw[23:0], b};
                    end
                    n_skip = r_skip - 6'd1;
                    if (n_skip == 6'd0) begin
                        n_phase = PH_LABEL;
                        n_skip  = LABEL_BYTES;
                        n_label = '0;
                    end
                end
                PH_LABEL: begin
                    n_label = {r_label[15:0], b};
                    n_skip  = r_skip - 6'd1;
                    if (n_skip == 6'd0) begin
                        n_phase = PH_TAIL;
                    end
                end
                default: begin
                end
            endcase

            // end of value or early buffer end
            if (in_value && !err) begin
                if ({1'b0, r_off} + 9'd1 >= {1'b0, r_vlen}) begin
                    if (n_phase == PH_IPB) begin
                        n_addr = '0;
                    end
                    if (n_phase == PH_GWB) begin
                        n_gw = '0;
                    end
                    if (n_phase == PH_LABEL) begin
                        n_label = '0;
                    end
                    o_emit                 = 1'b1;
                    o_result.status        = 1'b0;
                    o_result.rec_type      = n_type;
                    o_result.rd_asn        = n_asn;
                    o_result.rd_value      = n_rdval;
                    o_result.ethernet_tag  = n_tag;
                    o_result.mpls_label    = n_label[23:4];
                    o_result.mac_length    = n_maclen;
                    o_result.mac_address   = n_mac;
                    o_result.addr_length   = n_addrlen;
                    o_result.addr_value    = n_addr;
                    o_result.gateway_addr  = n_gw;
                    o_result.record_length = HDR_BYTES + {1'b0, r_vlen};
                    n_phase                = PH_TYPE;
                end else begin
                    n_off = r_off + 8'd1;
                    if (last) begin
                        err = 1'b1;
                    end
                end
            end

            if (err) begin
                o_emit          = 1'b1;
                o_result        = '0;
                o_result.status = 1'b1;
                n_phase         = PH_TYPE;
                n_draining      = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_draining <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_draining <= n_draining;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off     <= n_off;
        r_vlen    <= n_vlen;
        r_skip    <= n_skip;
        r_want    <= n_want;
        r_type    <= n_type;
        r_asn     <= n_asn;
        r_rdval   <= n_rdval;
        r_tag     <= n_tag;
        r_label   <= n_label;
        r_maclen  <= n_maclen;
        r_mac     <= n_mac;
        r_addrlen <= n_addrlen;
        r_addr    <= n_addr;
        r_gw      <= n_gw;
    end

endmodule

`default_nettype wire

### hdl/evpn_route_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// evpn_route_stream_decoder_core
// Decodes a byte stream of EVPN route records into one result per record.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle unless the input stalls. Each accepted byte lands
// in an input register and is parsed from there once the result register can
// take a new result; the parse state then advances and any result is written
// to the output register. The sustained rate is one byte per clock when the
// output does not stall; an output stall holds the parse stage, and the input
// stalls while its register is full and cannot advance. No clearing pass is
// needed after reset.
`default_nettype none

module evpn_route_stream_decoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_buffer_end,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_status,
    output logic [7:0]  o_rec_type,
    output logic [15:0] o_rd_asn,
    output logic [31:0] o_rd_value,
    output logic [31:0] o_ethernet_tag,
    output logic [19:0] o_mpls_label,
    output logic [7:0]  o_mac_length,
    output logic [47:0] o_mac_address,
    output logic [7:0]  o_addr_length,
    output logic [31:0] o_addr_value,
    output logic [31:0] o_gateway_addr,
    output logic [8:0]  o_record_length
);
    import evpn_rsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_route     r_out;

    logic   advance;
    logic   in_ready;
    t_step  step;
    logic   emit;
    t_route result;

    assign advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_ready = !r_in_valid || advance;
    assign o_in_stall = !in_ready;

    assign step.valid = advance;
    assign step.data  = r_in_data;
    assign step.last  = r_in_last;

    evpn_rsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_emit   (emit),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_ready) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_buffer_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_rec_type      = r_out.rec_type;
    assign o_rd_asn        = r_out.rd_asn;
    assign o_rd_value      = r_out.rd_value;
    assign o_ethernet_tag  = r_out.ethernet_tag;
    assign o_mpls_label    = r_out.mpls_label;
    assign o_mac_length    = r_out.mac_length;
    assign o_mac_address   = r_out.mac_address;
    assign o_addr_length   = r_out.addr_length;
    assign o_addr_value    = r_out.addr_value;
    assign o_gateway_addr  = r_out.gateway_addr;
    assign o_record_length = r_out.record_length;

    a_err_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_record_length == 9'd0)
        else $error("error result carries a record length");

    a_ok_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status |-> o_record_length >= 9'd25)
        else $error("decoded record shorter than the minimum");

    a_ok_known_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status |->
            (o_rec_type == RT_ETH_AD) || (o_rec_type == RT_MAC_IP) ||
            (o_rec_type == RT_INC_MCAST) || (o_rec_type == RT_IP_PREFIX))
        else $error("decoded record with unknown route type");

    a_mac_only_48: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mac_length != MAC_BITS) |-> o_mac_address == 48'd0)
        else $error("mac address set without a 48-bit length");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid && $stable(r_in_data))
        else $error("parse stage advanced into a stalled result register");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives EVPN route buffers into evpn_route_stream_decoder_core one byte per
// transfer and checks every decoded route against a byte-level parser model
// kept inside the bench. Directed records cover each route type, field
// extremes and malformed input. A random stream of mostly well-formed buffers
// with random content, truncated and corrupted buffers and raw noise follows.
// Both sides idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------

module testbench;
    import evpn_rsd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_status;
    logic [7:0]  o_rec_type;
    logic [15:0] o_rd_asn;
    logic [31:0] o_rd_value;
    logic [31:0] o_ethernet_tag;
    logic [19:0] o_mpls_label;
    logic [7:0]  o_mac_length;
    logic [47:0] o_mac_address;
    logic [7:0]  o_addr_length;
    logic [31:0] o_addr_value;
    logic [31:0] o_gateway_addr;
    logic [8:0]  o_record_length;

    evpn_route_stream_decoder_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_buffer_end    (i_buffer_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_rec_type      (o_rec_type),
        .o_rd_asn        (o_rd_asn),
        .o_rd_value      (o_rd_value),
        .o_ethernet_tag  (o_ethernet_tag),
        .o_mpls_label    (o_mpls_label),
        .o_mac_length    (o_mac_length),
        .o_mac_address   (o_mac_address),
        .o_addr_length   (o_addr_length),
        .o_addr_value    (o_addr_value),
        .o_gateway_addr  (o_gateway_addr),
        .o_record_length (o_record_length)
    );

    // parser model state
    t_phase      dec_phase   = PH_TYPE;
    logic [8:0]  dec_offset  = '0;
    logic [7:0]  dec_vlen    = '0;
    logic [5:0]  dec_skip    = '0;
    bit          dec_drain   = 1'b0;
    bit          dec_capture = 1'b0;
    logic [7:0]  rt_type     = '0;
    logic [15:0] rt_asn      = '0;
    logic [31:0] rt_rdval    = '0;
    logic [31:0] rt_tag      = '0;
    logic [23:0] rt_label    = '0;
    logic [7:0]  rt_maclen   = '0;
    logic [47:0] rt_mac      = '0;
    logic [7:0]  rt_addrlen  = '0;
    logic [31:0] rt_addr     = '0;
    logic [31:0] rt_gw       = '0;

    t_route      route_q[$];
    t_route      exp_route;
    logic [7:0]  val_q[$];
    logic [7:0]  buf_q[$];

    int mismatches     = 0;
    int routes_seen    = 0;
    int bad_routes     = 0;
    int bytes_accepted = 0;
    int parsed_bytes   = 0;
    int gap_pct        = 25;
    int stall_pct      = 25;
    int hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int bytes_of(input logic [7:0] bits);
        return (int'(bits) + 7) / 8;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("route %0d %s got %0h expected %0h",
                                      routes_seen, name, got, want_v));
    endtask

    task automatic route_error(input bit last);
        t_route r;
        r = '0;
        r.status = 1'b1;
        route_q.push_back(r);
        dec_phase = PH_TYPE;
        dec_drain = !last;
    endtask

    task automatic enter_label;
        dec_phase = PH_LABEL;
        dec_skip  = LABEL_BYTES;
        rt_label  = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input bit last);
        t_route     r;
        int         n;
        logic [7:0] need;
        if (dec_drain) begin
            if (last) begin
                dec_drain = 1'b0;
                dec_phase = PH_TYPE;
            end
            return;
        end
        parsed_bytes++;
        if (dec_phase == PH_TYPE) begin
            {rt_asn, rt_rdval, rt_tag, rt_label, rt_maclen} = '0;
            {rt_mac, rt_addrlen, rt_addr, rt_gw} = '0;
            dec_capture = 1'b0;
            rt_type = b;
            if ((b != RT_ETH_AD && b != RT_MAC_IP && b != RT_INC_MCAST &&
                 b != RT_IP_PREFIX) || last) begin
                route_error(last);
                return;
            end
            dec_phase = PH_LEN;
            return;
        end
        if (dec_phase == PH_LEN) begin
            dec_vlen = b;
            need = (rt_type == RT_ETH_AD) ? MIN_LEN_ETH_AD :
                   (rt_type == RT_MAC_IP) ? MIN_LEN_MAC_IP : MIN_LEN_OTHER;
            if (b < need || last) begin
                route_error(last);
                return;
            end
            dec_offset = '0;
            dec_phase  = PH_FIXED;
            return;
        end
        case (dec_phase)
            PH_FIXED: begin
                if (dec_offset >= OFF_ASN_FIRST && dec_offset <= OFF_ASN_LAST)
                    rt_asn = {rt_asn[7:0], b};
                else if (dec_offset >= OFF_RDVAL_FIRST && dec_offset <= OFF_RDVAL_LAST)
                    rt_rdval = {rt_rdval[23:0], b};
                else if (dec_offset >= OFF_TAG_FIRST && dec_offset <= OFF_TAG_LAST)
                    rt_tag = {rt_tag[23:0], b};
                if (dec_offset == OFF_TAG_LAST) begin
                    if (rt_type == RT_ETH_AD) enter_label();
                    else if (rt_type == RT_MAC_IP) dec_phase = PH_MACLEN;
                    else if (rt_type == RT_INC_MCAST) dec_phase = PH_IPLEN;
                    else dec_phase = PH_PLEN;
                end
            end
            PH_MACLEN: begin
                rt_maclen = b;
                n = bytes_of(b);
                if (n == 0) begin
                    dec_phase = PH_IPLEN;
                end else begin
                    dec_skip  = n[5:0];
                    dec_phase = PH_MACB;
                end
            end
            PH_MACB: begin
                if (rt_maclen == MAC_BITS) rt_mac = {rt_mac[39:0], b};
                dec_skip--;
                if (dec_skip == 0) dec_phase = PH_IPLEN;
            end
            PH_IPLEN: begin
                if (rt_type == RT_MAC_IP) rt_addrlen = b;
                dec_capture = (b == IPV4_BITS);
                n = bytes_of(b);
                if (n == 0) begin
                    enter_label();
                end else begin
                    dec_skip  = n[5:0];
                    dec_phase = PH_IPB;
                end
            end
            PH_IPB: begin
                if (dec_capture) rt_addr = {rt_addr[23:0], b};
                dec_skip--;
                if (dec_skip == 0) enter_label();
            end
            PH_PLEN: begin
                rt_addrlen = b;
                n = bytes_of(b);
                if (int'(OFF_PFX_FIRST) + n > int'(dec_vlen)) begin
                    route_error(last);
                    return;
                end
                if (n == 0) begin
                    dec_phase = PH_GWLEN;
                end else begin
                    dec_skip  = n[5:0];
                    dec_phase = PH_PFX;
                end
            end
            PH_PFX: begin
                n = int'(dec_offset) - int'(OFF_PFX_FIRST);
                if (n < 4) rt_addr = rt_addr | ({24'd0, b} << (24 - 8 * n));
                dec_skip--;
                if (dec_skip == 0) dec_phase = PH_GWLEN;
            end
            PH_GWLEN: begin
                dec_capture = (b == IPV4_BITS);
                n = bytes_of(b);
                if (n == 0) begin
                    enter_label();
                end else begin
                    dec_skip  = n[5:0];
                    dec_phase = PH_GWB;
                end
            end
            PH_GWB: begin
                if (dec_capture) rt_gw = {rt_gw[23:0], b};
                dec_skip--;
                if (dec_skip == 0) enter_label();
            end
            PH_LABEL: begin
                rt_label = {rt_label[15:0], b};
                dec_skip--;
                if (dec_skip == 0) dec_phase = PH_TAIL;
            end
            default: ;
        endcase
        if (int'(dec_offset) + 1 >= int'(dec_vlen)) begin
            // fields cut off by the end of the value read as zero
            if (dec_phase == PH_IPB) rt_addr = '0;
            if (dec_phase == PH_GWB) rt_gw = '0;
            if (dec_phase == PH_LABEL) rt_label = '0;
            r.status        = 1'b0;
            r.rec_type      = rt_type;
            r.rd_asn        = rt_asn;
            r.rd_value      = rt_rdval;
            r.ethernet_tag  = rt_tag;
            r.mpls_label    = rt_label[23:4];
            r.mac_length    = rt_maclen;
            r.mac_address   = rt_mac;
            r.addr_length   = rt_addrlen;
            r.addr_value    = rt_addr;
            r.gateway_addr  = rt_gw;
            r.record_length = HDR_BYTES + {1'b0, dec_vlen};
            route_q.push_back(r);
            dec_phase = PH_TYPE;
            return;
        end
        dec_offset = dec_offset + 9'd1;
        if (last) route_error(1'b1);
    endtask

    // results are checked before the same edge's input transfer is modeled
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (route_q.size() == 0) begin
                report_mismatch("route result with no record pending");
            end else begin
                exp_route = route_q.pop_front();
                routes_seen++;
                if (exp_route.status) bad_routes++;
                check_field("status", o_status, exp_route.status);
                check_field("rec_type", o_rec_type, exp_route.rec_type);
                check_field("rd_asn", o_rd_asn, exp_route.rd_asn);
                check_field("rd_value", o_rd_value, exp_route.rd_value);
                check_field("ethernet_tag", o_ethernet_tag, exp_route.ethernet_tag);
                check_field("mpls_label", o_mpls_label, exp_route.mpls_label);
                check_field("mac_length", o_mac_length, exp_route.mac_length);
                check_field("mac_address", o_mac_address, exp_route.mac_address);
                check_field("addr_length", o_addr_length, exp_route.addr_length);
                check_field("addr_value", o_addr_value, exp_route.addr_value);
                check_field("gateway_addr", o_gateway_addr, exp_route.gateway_addr);
                check_field("record_length", o_record_length, exp_route.record_length);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            bytes_accepted++;
            decode_byte(i_data_byte, i_buffer_end);
        end
    end

    // result side stall, with a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        @(negedge i_clk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_buffer_end <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic sender_idle;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_buffer;
        for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
    endtask

    task automatic val_rand(input int n);
        repeat (n) val_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic val_fill(input int n, input logic [7:0] v);
        repeat (n) val_q.push_back(v);
    endtask

    task automatic val_field(input logic [7:0] bits);
        val_q.push_back(bits);
        val_rand(bytes_of(bits));
    endtask

    // a negative length takes the value as built, capped at 255
    task automatic close_record(input logic [7:0] rtype, input int len);
        int l;
        l = (len < 0) ? ((val_q.size() > 255) ? 255 : val_q.size()) : len;
        buf_q.push_back(rtype);
        buf_q.push_back(8'(l));
        for (int i = 0; i < l && i < val_q.size(); i++) buf_q.push_back(val_q[i]);
        val_q.delete();
    endtask

    function automatic logic [7:0] pick_addr_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return IPV4_BITS;
        if (r < 8) return 8'd0;
        if (r < 9) return 8'd128;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic gen_route(input logic [7:0] rtype);
        int r;
        int len;
        val_rand(22);
        r = $urandom_range(0, 9);
        case (rtype)
            RT_ETH_AD: val_rand(3);
            RT_MAC_IP: begin
                val_field(r < 7 ? MAC_BITS : r < 8 ? 8'd0 : 8'($urandom_range(0, 255)));
                val_field(pick_addr_len());
                val_rand(3);
            end
            RT_INC_MCAST: begin
                val_field(pick_addr_len());
                if ($urandom_range(0, 1)) val_rand(3);
            end
            default: begin
                val_field(r < 6 ? 8'($urandom_range(0, 32)) :
                          r < 8 ? 8'd128 : 8'($urandom_range(0, 255)));
                val_field(pick_addr_len());
                val_rand(3);
            end
        endcase
        if ($urandom_range(0, 3) == 0) val_rand($urandom_range(1, 4));
        len = -1;
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(20, val_q.size() > 255 ? 255 : val_q.size());
        close_record(rtype, len);
    endtask

    task automatic gen_good_buffer(input int n);
        logic [7:0] kinds[4];
        kinds = '{RT_ETH_AD, RT_MAC_IP, RT_INC_MCAST, RT_IP_PREFIX};
        repeat (n) gen_route(kinds[$urandom_range(0, 3)]);
    endtask

    task automatic test_ethernet_ad;
        val_fill(22, 8'h00);
        val_fill(3, 8'h00);
        close_record(RT_ETH_AD, -1);
        val_fill(22, 8'hFF);
        val_fill(3, 8'hFF);
        close_record(RT_ETH_AD, -1);
        // trailing bytes past the label
        val_rand(35);
        close_record(RT_ETH_AD, -1);
        send_buffer();
    endtask

    task automatic test_mac_ip;
        val_rand(22);
        val_field(MAC_BITS);
        val_field(IPV4_BITS);
        val_rand(3);
        close_record(RT_MAC_IP, -1);
        val_rand(22);
        val_field(8'd0);
        val_field(8'd128);
        val_rand(3);
        close_record(RT_MAC_IP, -1);
        // odd mac length, no ip, label missing
        val_rand(22);
        val_field(8'd40);
        val_field(8'd0);
        close_record(RT_MAC_IP, -1);
        // value ends inside the ip address
        val_rand(22);
        val_field(MAC_BITS);
        val_field(IPV4_BITS);
        close_record(RT_MAC_IP, 32);
        // longest value
        val_fill(22, 8'hFF);
        val_field(MAC_BITS);
        val_field(IPV4_BITS);
        val_rand(255 - val_q.size());
        close_record(RT_MAC_IP, -1);
        send_buffer();
    endtask

    task automatic test_inclusive_mcast;
        val_rand(22);
        val_field(8'd0);
        close_record(RT_INC_MCAST, -1);
        val_rand(22);
        val_field(IPV4_BITS);
        val_rand(3);
        close_record(RT_INC_MCAST, -1);
        val_rand(22);
        val_field(8'd128);
        close_record(RT_INC_MCAST, -1);
        send_buffer();
    endtask

    task automatic test_ip_prefix;
        val_rand(22);
        val_field(8'd24);
        val_field(IPV4_BITS);
        val_rand(3);
        close_record(RT_IP_PREFIX, -1);
        // long prefix keeps its first four bytes
        val_rand(22);
        val_field(8'd128);
        val_field(8'd0);
        val_rand(3);
        close_record(RT_IP_PREFIX, -1);
        val_rand(22);
        val_field(8'd0);
        val_field(8'd128);
        val_rand(3);
        close_record(RT_IP_PREFIX, -1);
        val_rand(22);
        val_field(8'd255);
        val_field(IPV4_BITS);
        close_record(RT_IP_PREFIX, -1);
        send_buffer();
        // prefix past the value, the following record is drained
        val_rand(22);
        val_field(8'd8);
        close_record(RT_IP_PREFIX, 23);
        gen_good_buffer(1);
        send_buffer();
    endtask

    task automatic test_malformed;
        logic [7:0] unknown[3];
        unknown = '{8'd0, 8'd4, 8'd255};
        foreach (unknown[k]) begin
            val_rand(30);
            close_record(unknown[k], 30);
            send_buffer();
        end
        // unknown type on the flagged byte, no drain
        buf_q.push_back(8'd6);
        send_buffer();
        // short values
        val_rand(24);
        close_record(RT_ETH_AD, MIN_LEN_ETH_AD - 1);
        send_buffer();
        val_rand(28);
        close_record(RT_MAC_IP, MIN_LEN_MAC_IP - 1);
        send_buffer();
        val_rand(22);
        close_record(RT_INC_MCAST, MIN_LEN_OTHER - 1);
        send_buffer();
        val_rand(6);
        close_record(RT_IP_PREFIX, 0);
        send_buffer();
        // buffer ends inside the value, then on the type and length bytes
        val_rand(22);
        close_record(RT_MAC_IP, 40);
        send_buffer();
        buf_q.push_back(RT_ETH_AD);
        send_buffer();
        buf_q.push_back(RT_INC_MCAST);
        buf_q.push_back(8'd30);
        send_buffer();
        gen_good_buffer(2);
        send_buffer();
    endtask

    task automatic test_backpressure;
        gap_pct = 0;
        @(posedge i_clk);
        hold_left = 300;
        gen_good_buffer(6);
        send_buffer();
        gap_pct = 25;
    endtask

    task automatic test_random_stream;
        int start;
        int r;
        int k;
        start = bytes_accepted;
        while (bytes_accepted - start < 200 || bytes_accepted < 1300) begin
            gap_pct   = (bytes_accepted - start < 200) ? 0 : 25;
            stall_pct = gap_pct;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                gen_good_buffer($urandom_range(1, 4));
            end else if (r < 80) begin
                gen_good_buffer($urandom_range(0, 2));
                val_rand($urandom_range(0, 40));
                close_record(8'($urandom_range(0, 255)), $urandom_range(0, 255));
                gen_good_buffer($urandom_range(0, 1));
            end else if (r < 90) begin
                gen_good_buffer($urandom_range(1, 3));
                k = $urandom_range(1, buf_q.size() > 21 ? 20 : buf_q.size() - 1);
                repeat (k) buf_q.delete(buf_q.size() - 1);
            end else begin
                repeat ($urandom_range(1, 30)) buf_q.push_back(8'($urandom_range(0, 255)));
            end
            send_buffer();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = 8'd0;
        i_buffer_end = 1'b0;
        i_out_stall  = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_ethernet_ad();
        test_mac_ip();
        test_inclusive_mcast();
        test_ip_prefix();
        test_malformed();
        test_backpressure();
        test_random_stream();
        sender_idle();
        while (route_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("summary: %0d bytes transferred, %0d parsed outside drains",
                 bytes_accepted, parsed_bytes);
        $display("summary: %0d routes checked, %0d malformed, %0d mismatches",
                 routes_seen, bad_routes, mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

### files.f
hdl/evpn_rsd_pkg.sv
hdl/evpn_rsd_parser.sv
hdl/evpn_route_stream_decoder_core.sv
test/testbench.sv
